/* rtl/cqmq_pkg.sv */
`default_nettype none

package cqmq_pkg;

  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_POP   = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_POP  = 3'b010,
    ST_SCAN = 3'b100
  } state_e;

  localparam int unsigned CodeW   = 16;
  localparam int unsigned AmountW = 32;

  typedef struct packed {
    logic        [CodeW-1:0]   code;
    logic signed [AmountW-1:0] amount;
  } rec_t;

endpackage

`default_nettype wire

/* rtl/cqmq_store.sv */
`default_nettype none

module cqmq_store #(
  parameter int unsigned SLOTS = 8,
  parameter int unsigned IdxW  = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire                   clk_i,
  input  wire                   we_i,
  input  wire  [IdxW-1:0]       waddr_i,
  input  cqmq_pkg::rec_t        wdata_i,
  input  wire                   re_i,
  input  wire  [IdxW-1:0]       raddr_i,
  output cqmq_pkg::rec_t        rdata_o
);

  cqmq_pkg::rec_t mem_q [SLOTS];
  cqmq_pkg::rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/cqmq_ctrl.sv */
`default_nettype none

module cqmq_ctrl #(
  parameter int unsigned SLOTS = 8,
  parameter int unsigned IdxW  = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start_i,
  output logic                  busy_o,
  input  wire  [1:0]            func_i,
  input  cqmq_pkg::rec_t        rec_i,
  output logic                  mem_we_o,
  output logic [IdxW-1:0]       mem_waddr_o,
  output cqmq_pkg::rec_t        mem_wdata_o,
  output logic                  mem_re_o,
  output logic [IdxW-1:0]       mem_raddr_o,
  input  cqmq_pkg::rec_t        mem_rdata_i,
  output logic                  res_valid_o,
  output logic [1:0]            res_status_o,
  output cqmq_pkg::rec_t        res_rec_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);

  cqmq_pkg::state_e state_q, state_d;
  logic [IdxW-1:0]  head_q, head_d;
  logic [IdxW-1:0]  tail_q, tail_d;
  logic [IdxW-1:0]  ptr_q, ptr_d;
  logic             first_q, first_d;
  cqmq_pkg::rec_t   max_q, max_d;
  logic             res_valid_q, res_valid_d;
  logic [1:0]       res_status_q, res_status_d;
  cqmq_pkg::rec_t   res_rec_q, res_rec_d;

  logic [IdxW-1:0]  head_nxt, tail_nxt, ptr_nxt;
  logic             accept, empty, full, take;
  cqmq_pkg::func_e  func;

  assign head_nxt = (head_q == LastIdx) ? '0 : head_q + IdxW'(1);
  assign tail_nxt = (tail_q == LastIdx) ? '0 : tail_q + IdxW'(1);
  assign ptr_nxt  = (ptr_q  == LastIdx) ? '0 : ptr_q  + IdxW'(1);

  assign func   = cqmq_pkg::func_e'(func_i);
  assign busy_o = (state_q != cqmq_pkg::ST_IDLE);
  assign accept = start_i && !busy_o;
  assign empty  = (head_q == tail_q);
  assign full   = (tail_nxt == head_q);

  // first entry of a scan seeds the running maximum; ties keep the older entry
  assign take = first_q || ($signed(mem_rdata_i.amount) > $signed(max_q.amount));

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    ptr_d        = ptr_q;
    first_d      = first_q;
    max_d        = max_q;
    res_valid_d  = 1'b0;
    res_status_d = res_status_q;
    res_rec_d    = res_rec_q;
    mem_we_o     = 1'b0;
    mem_waddr_o  = tail_q;
    mem_wdata_o  = rec_i;
    mem_re_o     = 1'b0;
    mem_raddr_o  = head_q;

    case (state_q)
      cqmq_pkg::ST_IDLE: begin
        if (accept) begin
          res_status_d = cqmq_pkg::STAT_OK;
          res_rec_d    = '0;
          case (func)
            cqmq_pkg::FUNC_PUSH: begin
              res_valid_d = 1'b1;
              if (full) begin
                res_status_d = cqmq_pkg::STAT_FULL;
              end else begin
                mem_we_o = 1'b1;
                tail_d   = tail_nxt;
              end
            end
            cqmq_pkg::FUNC_POP, cqmq_pkg::FUNC_QUERY: begin
              if (empty) begin
                res_valid_d  = 1'b1;
                res_status_d = cqmq_pkg::STAT_EMPTY;
              end else begin
                mem_re_o = 1'b1;
                ptr_d    = head_nxt;
                first_d  = 1'b1;
                state_d  = (func == cqmq_pkg::FUNC_POP) ? cqmq_pkg::ST_POP
                                                         : cqmq_pkg::ST_SCAN;
              end
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end
      cqmq_pkg::ST_POP: begin
        res_valid_d = 1'b1;
        res_rec_d   = mem_rdata_i;
        head_d      = head_nxt;
        state_d     = cqmq_pkg::ST_IDLE;
      end
      cqmq_pkg::ST_SCAN: begin
        first_d = 1'b0;
        if (take) begin
          max_d = mem_rdata_i;
        end
        mem_raddr_o = ptr_q;
        // ptr_q reaching tail means the entry now on the read port is the last one
        if (ptr_q != tail_q) begin
          mem_re_o = 1'b1;
          ptr_d    = ptr_nxt;
        end else begin
          res_valid_d = 1'b1;
          res_rec_d   = max_d;
          state_d     = cqmq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cqmq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cqmq_pkg::ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      ptr_q       <= '0;
      first_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      ptr_q       <= ptr_d;
      first_q     <= first_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    max_q        <= max_d;
    res_status_q <= res_status_d;
    res_rec_q    <= res_rec_d;
  end

  assign res_valid_o  = res_valid_q;
  assign res_status_o = res_status_q;
  assign res_rec_o    = res_rec_q;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q <= LastIdx) && (tail_q <= LastIdx) && (ptr_q <= LastIdx))
    else $error("queue index out of range");

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (state_q == cqmq_pkg::ST_IDLE) && !full)
    else $error("memory write outside idle or into full queue");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cqmq_pkg::ST_SCAN || state_q == cqmq_pkg::ST_POP) |-> !empty)
    else $error("read of an empty queue");

  a_push_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |=> (tail_q == $past(tail_nxt)) && res_valid_q)
    else $error("push did not advance tail");

  a_res_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> $past(accept) || $past(busy_o))
    else $error("result without a transaction");

endmodule

`default_nettype wire

/* rtl/circular_queue_with_max_query_top.sv */
`default_nettype none

// Ring queue of (code, amount) records with SLOTS slots, holding at most SLOTS-1
// records. A transaction is taken when start is high and busy is low; each one
// gives exactly one result, shown for one cycle with result_valid_o. Push, the
// unused function code, and pop or query of an empty queue answer in the cycle
// after acceptance and leave busy low. A pop passes through the pop state, where the
// head record is registered as the result. A query holds busy high while its scan
// reads one record per cycle through the single read port of the record memory and
// gives the maximum. The receiver must take every result when it is shown.
module circular_queue_with_max_query_top #(
  parameter int unsigned SLOTS = 8
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start,
  output logic               busy,
  input  wire  [1:0]         func_i,
  input  wire  [15:0]        rec_code_i,
  input  wire  signed [31:0] rec_amount_i,
  output logic               result_valid_o,
  output logic [1:0]         status_o,
  output logic [15:0]        out_code_o,
  output logic signed [31:0] out_amount_o
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  cqmq_pkg::rec_t  rec_in, wdata, rdata, res_rec;
  logic            we, re;
  logic [IdxW-1:0] waddr, raddr;

  assign rec_in.code   = rec_code_i;
  assign rec_in.amount = rec_amount_i;

  cqmq_store #(
    .SLOTS (SLOTS),
    .IdxW  (IdxW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  cqmq_ctrl #(
    .SLOTS (SLOTS),
    .IdxW  (IdxW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_o       (busy),
    .func_i       (func_i),
    .rec_i        (rec_in),
    .mem_we_o     (we),
    .mem_waddr_o  (waddr),
    .mem_wdata_o  (wdata),
    .mem_re_o     (re),
    .mem_raddr_o  (raddr),
    .mem_rdata_i  (rdata),
    .res_valid_o  (result_valid_o),
    .res_status_o (status_o),
    .res_rec_o    (res_rec)
  );

  assign out_code_o   = res_rec.code;
  assign out_amount_o = res_rec.amount;

endmodule

`default_nettype wire

/* verif/tb_circular_queue_with_max_query_top.sv */
`timescale 1ns / 1ps

module tb_circular_queue_with_max_query_top;

  localparam int unsigned SLOTS        = 8;
  localparam int unsigned RANDOM_OPS   = 1200;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = SLOTS + 4;

  typedef struct {
    cqmq_pkg::func_e    op;
    logic [15:0]        code;
    logic signed [31:0] amount;
    int unsigned        gap;
    bit                 drain;   // hold off until all results are back
  } ring_op_t;

  typedef struct {
    cqmq_pkg::status_e  st;
    logic [15:0]        code;
    logic signed [31:0] amount;
  } ring_res_t;

  logic               clk_i  = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start  = 1'b0;
  logic [1:0]         func_drv = '0;
  logic [15:0]        code_drv = '0;
  logic signed [31:0] amt_drv  = '0;
  wire                busy;
  wire                result_valid_o;
  wire [1:0]          status_o;
  wire [15:0]         out_code_o;
  wire signed [31:0]  out_amount_o;

  // ring model state
  int unsigned        head_idx = 0;
  int unsigned        tail_idx = 0;
  logic [15:0]        code_mem [SLOTS];
  logic signed [31:0] amt_mem  [SLOTS];

  ring_op_t    ops_to_send [$];
  ring_res_t   results_due [$];
  ring_op_t    cur;
  bit          have_cur  = 1'b0;
  bit          sending   = 1'b0;
  int unsigned gap_left  = 0;
  int unsigned n_issued  = 0;
  int unsigned n_taken   = 0;
  int unsigned n_fail    = 0;
  int unsigned cycle_cnt = 0;

  circular_queue_with_max_query_top #(.SLOTS(SLOTS)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_drv),
    .rec_code_i     (code_drv),
    .rec_amount_i   (amt_drv),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .out_code_o     (out_code_o),
    .out_amount_o   (out_amount_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic int unsigned next_idx(int unsigned i);
    return (i + 1) % SLOTS;
  endfunction

  function automatic ring_res_t ring_apply(ring_op_t t);
    ring_res_t   r;
    int unsigned i;
    r.st     = cqmq_pkg::STAT_OK;
    r.code   = '0;
    r.amount = '0;
    case (t.op)
      cqmq_pkg::FUNC_PUSH: begin
        if (next_idx(tail_idx) == head_idx) begin
          r.st = cqmq_pkg::STAT_FULL;
        end else begin
          code_mem[tail_idx] = t.code;
          amt_mem[tail_idx]  = t.amount;
          tail_idx           = next_idx(tail_idx);
        end
      end
      cqmq_pkg::FUNC_POP: begin
        if (head_idx == tail_idx) begin
          r.st = cqmq_pkg::STAT_EMPTY;
        end else begin
          r.code   = code_mem[head_idx];
          r.amount = amt_mem[head_idx];
          head_idx = next_idx(head_idx);
        end
      end
      cqmq_pkg::FUNC_QUERY: begin
        if (head_idx == tail_idx) begin
          r.st = cqmq_pkg::STAT_EMPTY;
        end else begin
          r.code   = code_mem[head_idx];
          r.amount = amt_mem[head_idx];
          // strict compare keeps the tie nearest the front
          for (i = next_idx(head_idx); i != tail_idx; i = next_idx(i)) begin
            if (amt_mem[i] > r.amount) begin
              r.amount = amt_mem[i];
              r.code   = code_mem[i];
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void add_op(cqmq_pkg::func_e op, logic [15:0] code,
                                 logic signed [31:0] amount, int unsigned gap, bit drain);
    ring_op_t t;
    t.op     = op;
    t.code   = code;
    t.amount = amount;
    t.gap    = gap;
    t.drain  = drain;
    ops_to_send.push_back(t);
  endfunction

  // driver: inputs change on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (sending && n_taken == n_issued) begin
        sending  = 1'b0;
        have_cur = 1'b0;
      end
      if (!have_cur && ops_to_send.size() != 0) begin
        cur      = ops_to_send.pop_front();
        gap_left = cur.gap;
        have_cur = 1'b1;
      end
      if (have_cur && !sending) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (!cur.drain || results_due.size() == 0) begin
          sending = 1'b1;
          n_issued++;
        end
      end
      start <= sending;
      if (sending) begin
        func_drv <= cur.op;
        code_drv <= cur.code;
        amt_drv  <= cur.amount;
      end else begin
        func_drv <= 2'($urandom);
        code_drv <= 16'($urandom);
        amt_drv  <= $urandom;
      end
    end
  end

  // monitor: check results, then predict for the transaction taken at this edge
  always @(posedge clk_i) begin : mon
    ring_res_t want;
    ring_op_t  t;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (results_due.size() == 0) begin
          $error("result with no transaction outstanding: status %0d code %0h amount %0d",
                 status_o, out_code_o, out_amount_o);
          n_fail++;
        end else begin
          want = results_due.pop_front();
          if (status_o !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status_o);
            n_fail++;
          end
          if (out_code_o !== want.code) begin
            $error("out_code: expected %0h, got %0h", want.code, out_code_o);
            n_fail++;
          end
          if (out_amount_o !== want.amount) begin
            $error("out_amount: expected %0d, got %0d", want.amount, out_amount_o);
            n_fail++;
          end
        end
      end
      if (start && !busy) begin
        t.op     = cqmq_pkg::func_e'(func_drv);
        t.code   = code_drv;
        t.amount = amt_drv;
        t.gap    = 0;
        t.drain  = 1'b0;
        results_due.push_back(ring_apply(t));
        n_taken++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : main
    int unsigned        k;
    int unsigned        mode;
    int unsigned        gap_mode;
    int unsigned        push_pct;
    int unsigned        pop_pct;
    int unsigned        pick;
    int unsigned        gap;
    cqmq_pkg::func_e    op;
    logic signed [31:0] amt;

    // empty queue, unused code, then fill to full with extremes and a tied max
    add_op(cqmq_pkg::FUNC_QUERY, 16'hffff, 32'h7fffffff, 0, 1'b0);
    add_op(cqmq_pkg::FUNC_POP,   16'h0000, 32'h80000000, 0, 1'b0);
    add_op(cqmq_pkg::FUNC_NONE,  16'h1234, 32'h00000001, 0, 1'b0);
    add_op(cqmq_pkg::FUNC_PUSH,  16'h0000, 32'h80000000, 0, 1'b0);
    add_op(cqmq_pkg::FUNC_PUSH,  16'hffff, 32'h7fffffff, 0, 1'b0);
    add_op(cqmq_pkg::FUNC_PUSH,  16'h5555, 32'h00000000, 3, 1'b0);
    add_op(cqmq_pkg::FUNC_PUSH,  16'haaaa, 32'hffffffff, 0, 1'b0);
    add_op(cqmq_pkg::FUNC_NONE,  16'hffff, 32'hffffffff, 0, 1'b0);
    add_op(cqmq_pkg::FUNC_PUSH,  16'h0001, 32'h7fffffff, 0, 1'b0);
    add_op(cqmq_pkg::FUNC_PUSH,  16'h8000, 32'h80000001, 0, 1'b0);
    add_op(cqmq_pkg::FUNC_PUSH,  16'h7fff, 32'h00000064, 0, 1'b0);
    add_op(cqmq_pkg::FUNC_PUSH,  16'h0f0f, 32'h00000001, 0, 1'b0);
    add_op(cqmq_pkg::FUNC_QUERY, 16'h0000, 32'h00000000, 0, 1'b1);
    for (k = 0; k < SLOTS - 1; k++) begin
      add_op(cqmq_pkg::FUNC_POP, 16'($urandom), $urandom, (k == 2) ? 15 : 0, 1'b0);
    end
    add_op(cqmq_pkg::FUNC_POP,   16'h0000, 32'h00000000, 0, 1'b0);
    add_op(cqmq_pkg::FUNC_QUERY, 16'h0000, 32'h00000000, 0, 1'b0);

    for (k = 0; k < RANDOM_OPS; k++) begin
      if (k % 40 == 0) begin
        mode     = $urandom_range(0, 2);
        gap_mode = $urandom_range(0, 2);
      end
      push_pct = (mode == 0) ? 60 : (mode == 1) ? 25 : 40;
      pop_pct  = (mode == 0) ? 20 : (mode == 1) ? 50 : 30;
      pick     = $urandom_range(0, 99);
      if (pick < push_pct) op = cqmq_pkg::FUNC_PUSH;
      else if (pick < push_pct + pop_pct) op = cqmq_pkg::FUNC_POP;
      else if (pick < 96) op = cqmq_pkg::FUNC_QUERY;
      else op = cqmq_pkg::FUNC_NONE;
      case ($urandom_range(0, 3))
        1: amt = $signed($urandom_range(0, 6)) - 3;   // small range makes ties
        2: begin
          case ($urandom_range(0, 3))
            0: amt = 32'h80000000;
            1: amt = 32'h7fffffff;
            2: amt = 32'h00000000;
            default: amt = 32'hffffffff;
          endcase
        end
        default: amt = $urandom;
      endcase
      case (gap_mode)
        0: gap = 0;
        1: gap = $urandom_range(0, 15);
        default: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
      endcase
      add_op(op, 16'($urandom), amt, gap, $urandom_range(0, 59) == 0);
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (have_cur || ops_to_send.size() != 0 || results_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (n_fail == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
